@@ rtl/lpr_pkg.sv @@
// Shared constants, codes and types for the looping pitch resampler.
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int DEF_LOOP_DEPTH = 4096;
  localparam int DEF_FRAC_BITS  = 8;

  localparam int ADDR_W   = 12;
  localparam int SAMPLE_W = 16;
  localparam int PITCH_W  = 12;
  localparam int CFG_W    = 13;

  localparam int MIN_LOOP_LOG2 = 4;
  localparam int MIN_LOOP      = 1 << MIN_LOOP_LOG2;
  localparam int LOOP_LEN_RST  = 4096;

  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32767;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_GEN   = 1'b1;

  typedef struct packed {
    logic cfg_we;
    logic step;
  } pos_ctl_t;

endpackage

@@ rtl/lpr_pos.sv @@
// Read position accumulator with loop wrap, loop length register and post-config reduction.
`timescale 1ns / 1ps

module lpr_pos #(
  parameter int LOOP_DEPTH = lpr_pkg::DEF_LOOP_DEPTH,
  parameter int FRAC_BITS  = lpr_pkg::DEF_FRAC_BITS,
  localparam int IDX_W = $clog2(LOOP_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpr_pkg::pos_ctl_t           ctl_i,
  input  logic [lpr_pkg::CFG_W-1:0]   cfg_len_i,
  input  logic [lpr_pkg::PITCH_W-1:0] pitch_i,
  output logic                        busy_o,
  output logic [IDX_W-1:0]            i1_o,
  output logic [IDX_W-1:0]            i2_o,
  output logic [FRAC_BITS-1:0]        frac_o
);

  localparam int LEN_W = $clog2(LOOP_DEPTH + 1);
  localparam int POS_W = IDX_W + FRAC_BITS;
  localparam int CL_W  = (LEN_W > lpr_pkg::CFG_W) ? LEN_W : lpr_pkg::CFG_W;
  localparam int RED_STEPS = (IDX_W > lpr_pkg::MIN_LOOP_LOG2 + 1) ?
                             IDX_W - lpr_pkg::MIN_LOOP_LOG2 : 1;
  localparam int RC_W = $clog2(RED_STEPS + 1);
  localparam int RW   = LEN_W + RED_STEPS;
  localparam int WRAP_STEPS = (lpr_pkg::PITCH_W > lpr_pkg::MIN_LOOP_LOG2 + FRAC_BITS) ?
                              lpr_pkg::PITCH_W - lpr_pkg::MIN_LOOP_LOG2 - FRAC_BITS + 1 : 1;
  localparam int SUM_W = ((POS_W > lpr_pkg::PITCH_W) ? POS_W : lpr_pkg::PITCH_W) + 1;
  localparam int LIM_W = LEN_W + FRAC_BITS + WRAP_STEPS;
  localparam int WW    = (SUM_W > LIM_W) ? SUM_W : LIM_W;
  localparam logic [LEN_W-1:0] LEN_RST =
    LEN_W'((lpr_pkg::LOOP_LEN_RST < LOOP_DEPTH) ? lpr_pkg::LOOP_LEN_RST : LOOP_DEPTH);

  logic [LEN_W-1:0] len_r, len_nxt, len_cfg;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_step;
  logic [RC_W-1:0]  red_cnt_r, red_cnt_nxt, red_k;
  logic [CL_W-1:0]  cfg_ext;
  logic [RW-1:0]    red_ext, red_cmp;
  logic [IDX_W-1:0] red_int;
  logic [SUM_W-1:0] sum;
  logic [WW-1:0]    wrap;
  logic [LEN_W-1:0] i1_inc;

  assign busy_o = (red_cnt_r != '0);

  // effective loop length saturates into [MIN_LOOP, LOOP_DEPTH]
  always_comb begin
    cfg_ext = CL_W'(cfg_len_i);
    if (cfg_ext < CL_W'(lpr_pkg::MIN_LOOP)) begin
      len_cfg = LEN_W'(lpr_pkg::MIN_LOOP);
    end else if (cfg_ext > CL_W'(LOOP_DEPTH)) begin
      len_cfg = LEN_W'(LOOP_DEPTH);
    end else begin
      len_cfg = cfg_ext[LEN_W-1:0];
    end
  end

  // one restoring step per cycle: integer position mod new length
  always_comb begin
    red_k   = RC_W'(red_cnt_r - 1'b1);
    red_ext = RW'(pos_r[POS_W-1:FRAC_BITS]);
    red_cmp = RW'(len_r) << red_k;
    if (red_ext >= red_cmp) begin
      red_int = IDX_W'(red_ext - red_cmp);
    end else begin
      red_int = pos_r[POS_W-1:FRAC_BITS];
    end
  end

  // accumulate and wrap; position is already below the loop end
  always_comb begin
    sum  = SUM_W'(pos_r) + SUM_W'(pitch_i);
    wrap = WW'(sum);
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      if (wrap >= (WW'(len_r) << (FRAC_BITS + k))) begin
        wrap = wrap - (WW'(len_r) << (FRAC_BITS + k));
      end
    end
    pos_step = wrap[POS_W-1:0];
  end

  always_comb begin
    i1_o   = pos_step[POS_W-1:FRAC_BITS];
    frac_o = pos_step[FRAC_BITS-1:0];
    i1_inc = LEN_W'(i1_o) + 1'b1;
    if (i1_inc >= len_r) begin
      i2_o = '0;
    end else begin
      i2_o = i1_inc[IDX_W-1:0];
    end
  end

  always_comb begin
    len_nxt     = ctl_i.cfg_we ? len_cfg : len_r;
    red_cnt_nxt = red_cnt_r;
    pos_nxt     = pos_r;
    if (ctl_i.cfg_we) begin
      red_cnt_nxt = RC_W'(RED_STEPS);
    end else if (busy_o) begin
      red_cnt_nxt = red_k;
    end
    if (busy_o) begin
      pos_nxt = {red_int, pos_r[FRAC_BITS-1:0]};
    end else if (ctl_i.step) begin
      pos_nxt = pos_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_RST;
      pos_r     <= '0;
      red_cnt_r <= '0;
    end else begin
      len_r     <= len_nxt;
      pos_r     <= pos_nxt;
      red_cnt_r <= red_cnt_nxt;
    end
  end

  ap_pos_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_o |-> (LEN_W'(pos_r[POS_W-1:FRAC_BITS]) < len_r))
    else $error("read position beyond loop end");

  ap_no_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_o |-> !ctl_i.step)
    else $error("position step during reduction");

endmodule

@@ rtl/lpr_interp.sv @@
// Interpolation multiply stage and clamped output register.
`timescale 1ns / 1ps

module lpr_interp #(
  parameter int FRAC_BITS = lpr_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                en_mul_i,
  input  logic                                en_out_i,
  input  logic signed [lpr_pkg::SAMPLE_W-1:0] rd1_i,
  input  logic signed [lpr_pkg::SAMPLE_W-1:0] rd2_i,
  input  logic        [FRAC_BITS-1:0]         frac_i,
  output logic signed [lpr_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int DW = lpr_pkg::SAMPLE_W + 1;
  localparam int PW = DW + FRAC_BITS + 1;
  localparam int YW = lpr_pkg::SAMPLE_W + 3;
  localparam logic signed [YW-1:0] Y_MAX = YW'(lpr_pkg::OUT_MAX);
  localparam logic signed [YW-1:0] Y_MIN = YW'(lpr_pkg::OUT_MIN);

  logic signed [DW-1:0]               diff;
  logic signed [PW-1:0]               prod_nxt, prod_r, shr;
  logic signed [lpr_pkg::SAMPLE_W-1:0] base_r, sample_r, sample_nxt;
  logic signed [YW-1:0]               y;

  always_comb begin
    diff     = DW'(rd2_i) - DW'(rd1_i);
    prod_nxt = PW'(diff) * PW'($signed({1'b0, frac_i}));
  end

  // arithmetic shift gives floor of the scaled offset
  always_comb begin
    shr = prod_r >>> FRAC_BITS;
    y   = YW'(base_r) + YW'(shr);
    if (y > Y_MAX) begin
      sample_nxt = Y_MAX[lpr_pkg::SAMPLE_W-1:0];
    end else if (y < Y_MIN) begin
      sample_nxt = Y_MIN[lpr_pkg::SAMPLE_W-1:0];
    end else begin
      sample_nxt = y[lpr_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul_i) begin
      prod_r <= prod_nxt;
      base_r <= rd1_i;
    end
    if (en_out_i) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample_o = sample_r;

endmodule

@@ rtl/looping_pitch_resampler.sv @@
// Looping pitch resampler: top level with loop memory and stage control.
//
// Input channel in_*: each transfer is either a loop sample write
// (in_func = write, in_address, in_sample_in) or a generate request
// (in_func = generate, in_pitch_step). Writes produce no result; each
// generate produces one out_sample_out transfer, in order.
// cfg_we / cfg_wdata load the loop length, saturated to [16, LOOP_DEPTH].
// After each config write the read position is reduced into the new
// loop, one quotient bit per cycle, while a held item waits in the input
// register. A generate result passes the input register, position update,
// memory read, multiply and clamp/output stages, in that order.
// Throughput: one item per clock while not stalled, limited by the single
// position accumulate feeding the two-port memory read each cycle.
// Reset (rst_n low, synchronous) empties all stages, zeroes the read
// position and sets the loop length to its maximum; memory is not cleared.
// When out_stall is high the result holds and earlier stages keep filling
// any empty slots; in_stall rises once the input register cannot move on.
`timescale 1ns / 1ps

module looping_pitch_resampler #(
  parameter int LOOP_DEPTH = lpr_pkg::DEF_LOOP_DEPTH,
  parameter int FRAC_BITS  = lpr_pkg::DEF_FRAC_BITS,
  localparam int IDX_W = $clog2(LOOP_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic        [lpr_pkg::ADDR_W-1:0]   in_address,
  input  logic signed [lpr_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic        [lpr_pkg::PITCH_W-1:0]  in_pitch_step,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lpr_pkg::SAMPLE_W-1:0] out_sample_out,
  input  logic                                cfg_we,
  input  logic        [lpr_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int LEN_W = $clog2(LOOP_DEPTH + 1);
  localparam int AW    = (LEN_W > lpr_pkg::ADDR_W) ? LEN_W : lpr_pkg::ADDR_W;

  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  logic free1, free2, free3, free4, free_o;
  logic busy, mv2;
  lpr_pkg::pos_ctl_t pos_ctl;

  logic                                func1_r, func2_r;
  logic        [lpr_pkg::ADDR_W-1:0]   addr1_r, addr2_r;
  logic signed [lpr_pkg::SAMPLE_W-1:0] smp1_r, smp2_r;
  logic        [lpr_pkg::PITCH_W-1:0]  pitch1_r;
  logic        [IDX_W-1:0]             i1_nxt, i2_nxt, i1_2_r, i2_2_r;
  logic        [FRAC_BITS-1:0]         frac_nxt, frac2_r, frac3_r;
  logic signed [lpr_pkg::SAMPLE_W-1:0] rd1_r, rd2_r;
  logic        [AW-1:0]                addr_ext;
  logic                                wr_ok;

  logic signed [lpr_pkg::SAMPLE_W-1:0] mem [LOOP_DEPTH];

  // stage control: a stage loads when empty or when it moves on
  assign free_o = !vo_r || !out_stall;
  assign free4  = !v4_r || free_o;
  assign free3  = !v3_r || free4;
  assign free2  = !v2_r || free3;
  assign free1  = !v1_r || (free2 && !busy);
  assign mv2    = v1_r && free2 && !busy;

  assign in_stall  = !free1;
  assign out_valid = vo_r;

  assign pos_ctl.cfg_we = cfg_we;
  assign pos_ctl.step   = mv2 && (func1_r == lpr_pkg::FUNC_GEN);

  lpr_pos #(
    .LOOP_DEPTH (LOOP_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (pos_ctl),
    .cfg_len_i (cfg_wdata),
    .pitch_i   (pitch1_r),
    .busy_o    (busy),
    .i1_o      (i1_nxt),
    .i2_o      (i2_nxt),
    .frac_o    (frac_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_valid;
      if (free2) v2_r <= v1_r && !busy;
      if (free3) v3_r <= v2_r && (func2_r == lpr_pkg::FUNC_GEN);
      if (free4) v4_r <= v3_r;
      if (free_o) vo_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      func1_r  <= in_func;
      addr1_r  <= in_address;
      smp1_r   <= in_sample_in;
      pitch1_r <= in_pitch_step;
    end
    if (free2) begin
      func2_r <= func1_r;
      addr2_r <= addr1_r;
      smp2_r  <= smp1_r;
      i1_2_r  <= i1_nxt;
      i2_2_r  <= i2_nxt;
      frac2_r <= frac_nxt;
    end
  end

  // writes beyond the memory are dropped
  assign addr_ext = AW'(addr2_r);
  assign wr_ok    = addr_ext < AW'(LOOP_DEPTH);

  // writes and reads share one stage, so item order is kept
  always_ff @(posedge clk) begin
    if (free3) begin
      if (v2_r && (func2_r == lpr_pkg::FUNC_WRITE) && wr_ok) begin
        mem[addr_ext[IDX_W-1:0]] <= smp2_r;
      end
      rd1_r   <= mem[i1_2_r];
      rd2_r   <= mem[i2_2_r];
      frac3_r <= frac2_r;
    end
  end

  lpr_interp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_interp (
    .clk      (clk),
    .en_mul_i (free4),
    .en_out_i (free_o),
    .rd1_i    (rd1_r),
    .rd2_i    (rd2_r),
    .frac_i   (frac3_r),
    .sample_o (out_sample_out)
  );

  ap_out_from_mul: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(v4_r))
    else $error("result without multiply stage item");

  ap_mul_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !v3_r |=> !v4_r || $past(v4_r && !free_o))
    else $error("multiply stage valid without source");

  ap_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && (func2_r == lpr_pkg::FUNC_WRITE) && free3) |=> !v3_r)
    else $error("sample write passed toward output");

endmodule

@@ verif/tb_looping_pitch_resampler.sv @@
// Self-checking testbench for the looping pitch resampler.
`timescale 1ns / 1ps

module tb_looping_pitch_resampler;

  localparam int LOOP_DEPTH   = lpr_pkg::DEF_LOOP_DEPTH;
  localparam int FRAC_BITS    = lpr_pkg::DEF_FRAC_BITS;
  localparam int ITEM_TARGET  = 1600;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 20;

  logic                                clk;
  logic                                rst_n         = 1'b0;
  logic                                in_valid      = 1'b0;
  logic                                in_stall;
  logic                                in_func       = lpr_pkg::FUNC_WRITE;
  logic        [lpr_pkg::ADDR_W-1:0]   in_address    = '0;
  logic signed [lpr_pkg::SAMPLE_W-1:0] in_sample_in  = '0;
  logic        [lpr_pkg::PITCH_W-1:0]  in_pitch_step = '0;
  logic                                out_valid;
  logic                                out_stall     = 1'b0;
  logic signed [lpr_pkg::SAMPLE_W-1:0] out_sample_out;
  logic                                cfg_we        = 1'b0;
  logic        [lpr_pkg::CFG_W-1:0]    cfg_wdata     = '0;

  looping_pitch_resampler DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_address    (in_address),
    .in_sample_in  (in_sample_in),
    .in_pitch_step (in_pitch_step),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // Shadow of the block state
  logic signed [lpr_pkg::SAMPLE_W-1:0] loop_mem [LOOP_DEPTH];
  bit                                  written  [LOOP_DEPTH];
  int unsigned                         play_pos = 0;
  logic        [lpr_pkg::CFG_W-1:0]    loop_len_reg = lpr_pkg::CFG_W'(lpr_pkg::LOOP_LEN_RST);
  logic signed [lpr_pkg::SAMPLE_W-1:0] pending_samples [$];

  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int cycle_cnt    = 0;
  int sink_wait    = 0;
  int hold_left    = 0;
  bit src_gaps     = 1'b1;
  bit sink_gaps    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic int unsigned active_length();
    int unsigned n;
    n = loop_len_reg;
    if (n < lpr_pkg::MIN_LOOP) n = lpr_pkg::MIN_LOOP;
    if (n > LOOP_DEPTH) n = LOOP_DEPTH;
    return n;
  endfunction

  function automatic int unsigned stepped_position(logic [lpr_pkg::PITCH_W-1:0] pitch);
    int unsigned span;
    int unsigned pos;
    span = active_length() << FRAC_BITS;
    pos = play_pos + pitch;
    if (pos >= span) pos = pos % span;
    return pos;
  endfunction

  function automatic int unsigned next_index(int unsigned idx);
    return (idx + 1 >= active_length()) ? 0 : idx + 1;
  endfunction

  function automatic logic signed [lpr_pkg::SAMPLE_W-1:0] interpolate(int unsigned pos);
    int unsigned i1;
    int unsigned frac;
    int s1;
    int s2;
    int y;
    i1 = pos >> FRAC_BITS;
    frac = pos & ((1 << FRAC_BITS) - 1);
    s1 = loop_mem[i1];
    s2 = loop_mem[next_index(i1)];
    y = s1 + (((s2 - s1) * int'(frac)) >>> FRAC_BITS);
    if (y > lpr_pkg::OUT_MAX) y = lpr_pkg::OUT_MAX;
    else if (y < lpr_pkg::OUT_MIN) y = lpr_pkg::OUT_MIN;
    return y[lpr_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic signed [lpr_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return lpr_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [lpr_pkg::PITCH_W-1:0] random_pitch();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2: return lpr_pkg::PITCH_W'($urandom_range(1, 255));
      default: return lpr_pkg::PITCH_W'($urandom);
    endcase
  endfunction

  function automatic logic [lpr_pkg::CFG_W-1:0] random_length();
    case ($urandom_range(0, 9))
      0: return lpr_pkg::CFG_W'($urandom_range(0, lpr_pkg::MIN_LOOP - 1));
      1: return lpr_pkg::CFG_W'($urandom_range(LOOP_DEPTH, (1 << lpr_pkg::CFG_W) - 1));
      2: return lpr_pkg::CFG_W'($urandom_range(lpr_pkg::MIN_LOOP, LOOP_DEPTH));
      default: return lpr_pkg::CFG_W'($urandom_range(lpr_pkg::MIN_LOOP,
                                                      4 * lpr_pkg::MIN_LOOP));
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < MAX_REPORTS) $display("[%0t] MISMATCH: %s", $realtime, what);
    errors++;
  endtask

  // One input transfer; state and expected samples are updated at acceptance.
  task automatic send_item(input logic func, input logic [lpr_pkg::ADDR_W-1:0] addr,
                           input logic signed [lpr_pkg::SAMPLE_W-1:0] smp,
                           input logic [lpr_pkg::PITCH_W-1:0] pitch);
    int gap;
    gap = src_gaps ? draw_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_address    <= addr;
    in_sample_in  <= smp;
    in_pitch_step <= pitch;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (func == lpr_pkg::FUNC_WRITE) begin
      loop_mem[addr] = smp;
      written[addr]  = 1'b1;
    end else begin
      play_pos = stepped_position(pitch);
      pending_samples.push_back(interpolate(play_pos));
    end
  endtask

  task automatic write_sample(input logic [lpr_pkg::ADDR_W-1:0] addr,
                              input logic signed [lpr_pkg::SAMPLE_W-1:0] smp);
    send_item(lpr_pkg::FUNC_WRITE, addr, smp, lpr_pkg::PITCH_W'($urandom));
  endtask

  // Fills any entry the next read would touch before it is read.
  task automatic play_sample(input logic [lpr_pkg::PITCH_W-1:0] pitch);
    int unsigned i1;
    int unsigned i2;
    i1 = stepped_position(pitch) >> FRAC_BITS;
    i2 = next_index(i1);
    if (!written[i1]) write_sample(lpr_pkg::ADDR_W'(i1), random_sample());
    if (!written[i2]) write_sample(lpr_pkg::ADDR_W'(i2), random_sample());
    send_item(lpr_pkg::FUNC_GEN, lpr_pkg::ADDR_W'($urandom),
              lpr_pkg::SAMPLE_W'($urandom), pitch);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [lpr_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    loop_len_reg = value;
    cfg_writes++;
  endtask

  task automatic test_clamp_and_zero_pitch();
    write_sample(0, 16'sh8000);
    write_sample(1, 16'sh8000);
    write_sample(2, 16'sh7fff);
    write_sample(12'hfff, 16'sh7fff);
    play_sample(12'h000);
    play_sample(12'h000);
    play_sample(12'h180);
    play_sample(12'hfff);
  endtask

  task automatic test_length_limits();
    write_length('1);
    play_sample(12'h100);
    write_length('0);
    play_sample(12'h0ff);
    play_sample(12'hfff);
    write_length(lpr_pkg::CFG_W'(lpr_pkg::MIN_LOOP - 1));
    play_sample(12'h7ff);
    write_length(lpr_pkg::CFG_W'(LOOP_DEPTH + 1));
    play_sample(12'h010);
    write_length(lpr_pkg::CFG_W'(lpr_pkg::MIN_LOOP));
    play_sample(12'h0f0);
    write_length(lpr_pkg::CFG_W'(LOOP_DEPTH));
    play_sample(12'h800);
  endtask

  // Output held off for a long stretch while input keeps coming.
  task automatic test_backpressure();
    int k;
    src_gaps = 1'b0;
    hold_left <= HOLD_CYCLES;
    for (k = 0; k < 40; k++) play_sample(random_pitch());
    src_gaps = 1'b1;
  endtask

  task automatic test_random_phases();
    int n;
    int k;
    while (items_sent < ITEM_TARGET) begin
      write_length(random_length());
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 80);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 9) < 3) begin
          write_sample(lpr_pkg::ADDR_W'($urandom), random_sample());
        end else begin
          play_sample(random_pitch());
        end
      end
    end
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
  endtask

  always @(posedge clk) begin : result_check
    logic signed [lpr_pkg::SAMPLE_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("unexpected sample_out %0d", out_sample_out));
      end else begin
        want = pending_samples.pop_front();
        if (out_sample_out !== want)
          report_mismatch($sformatf("sample_out: expected %0d, got %0d", want,
                                    out_sample_out));
      end
      sink_wait = sink_gaps ? draw_gap() : 0;
    end else if (sink_wait > 0) begin
      sink_wait--;
    end
    out_stall <= (sink_wait > 0) || (hold_left > 0);
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d samples outstanding", cycle_cnt,
             pending_samples.size());
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_clamp_and_zero_pitch();
    test_length_limits();
    test_backpressure();
    test_random_phases();
    wait_idle();
    $display("Sent %0d input transfers, checked %0d output samples, %0d loop length writes.",
             items_sent, results_seen, cfg_writes);
    $display("Covered length saturation and shrink, zero and full pitch, clamping, hold-off.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
